FILE: rtl/core/mlcf_pkg.sv
// Shared types, constants and lookup functions for the motor link command framer.
`timescale 1ns / 1ps

package mlcf_pkg;

  // Width of the millisecond idle timer.
  localparam int TIMER_BITS = 8;
  // Width used when comparing the timer against an 8-bit timeout register.
  localparam int LIM_W = (TIMER_BITS > 8) ? TIMER_BITS : 8;
  localparam int TICK_MAX_I = (1 << TIMER_BITS) - 1;

  // Frame constants.
  localparam logic [7:0] FRAME_HEAD = 8'h7A;
  localparam logic [7:0] FRAME_TAIL = 8'h7B;
  localparam logic [15:0] ANGLE_MAX = 16'd3599;
  localparam logic [3:0] REPLY_LAST = 4'd8;
  localparam logic [3:0] REPLY_CHK = 4'd7;

  // Timeout reset values.
  localparam logic [7:0] FIRST_TO_RST = 8'd12;
  localparam logic [7:0] NEXT_TO_RST = 8'd5;

  // Command queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEXT_TO = 1'd1;

  typedef enum logic [1:0] {
    MODE_SEND = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_TICK = 2'd2,
    MODE_NONE = 2'd3
  } mode_e_t;

  typedef enum logic [2:0] {
    OP_ENABLE   = 3'd0,
    OP_DISABLE  = 3'd1,
    OP_SET_MODE = 3'd2,
    OP_SPEED    = 3'd3,
    OP_POSITION = 3'd4,
    OP_ANGLE    = 3'd5,
    OP_ACCEL    = 3'd6,
    OP_FEEDBACK = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_OK   = 2'd1,
    ST_FAIL = 2'd2
  } status_t;

  // One unit of work for the back end: a frame to emit or a reply result.
  typedef struct packed {
    logic        is_reply;
    opcode_t     opcode;
    logic [7:0]  addr;
    logic [31:0] value;
    status_t     status;
  } desc_t;

  // Wire code of each command.
  function automatic logic [7:0] wire_code(input opcode_t op);
    logic [7:0] code;
    unique case (op)
      OP_ENABLE:   code = 8'h06;
      OP_DISABLE:  code = 8'h05;
      OP_SET_MODE: code = 8'h00;
      OP_SPEED:    code = 8'h01;
      OP_POSITION: code = 8'h02;
      OP_ANGLE:    code = 8'h03;
      OP_ACCEL:    code = 8'h07;
      OP_FEEDBACK: code = 8'h0E;
      default:     code = 8'h00;
    endcase
    return code;
  endfunction

  // Payload length in bytes of each command.
  function automatic logic [2:0] payload_len(input opcode_t op);
    logic [2:0] len;
    unique case (op)
      OP_ENABLE, OP_DISABLE:                       len = 3'd0;
      OP_SET_MODE, OP_SPEED, OP_ANGLE, OP_ACCEL:   len = 3'd2;
      OP_POSITION:                                 len = 3'd4;
      OP_FEEDBACK:                                 len = 3'd1;
      default:                                     len = 3'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/core/mlcf_if.sv
// Channel interfaces of the motor link command framer: input, result and configuration.
`timescale 1ns / 1ps

interface mlcf_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [2:0]         opcode;
  logic [7:0]         device_addr;
  logic signed [31:0] argument;
  logic [7:0]         rx_byte;

  modport source (output valid, mode, opcode, device_addr, argument, rx_byte,
                  input ready);
  modport sink (input valid, mode, opcode, device_addr, argument, rx_byte,
                output ready);
endinterface

interface mlcf_out_if;
  logic               valid;
  logic               ready;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               tx_last;
  logic [1:0]         reply_status;
  logic signed [31:0] reply_value;

  modport source (output valid, tx_valid, tx_byte, tx_last, reply_status, reply_value,
                  input ready);
  modport sink (input valid, tx_valid, tx_byte, tx_last, reply_status, reply_value,
                output ready);
endinterface

interface mlcf_cfg_if;
  import mlcf_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/motor_link_command_framer_unit.sv
// Top level of the motor link command framer.
`timescale 1ns / 1ps
//
// Requests enter on in_if: mode 0 frames a command, mode 1 delivers a received
// serial byte, mode 2 marks one millisecond tick. Results leave on out_if, either
// a frame byte (tx_valid set, tx_last on the tail) or a reply outcome.
// Timeouts are written through cfg_if; the user must write them only while the block
// is idle, as the block does not enforce it. cfg_if is always ready. A send request
// yields five to nine frame bytes, one per cycle while the receiver is ready,
// produced by the back end from the head of a four-entry work queue. Byte and tick
// requests are taken one per cycle by the front end while the queue is not full
// and yield at most one result. In an idle block a request enters the queue at
// acceptance and its first result reaches the output register in the next cycle.
// Sustained: one request per cycle for byte and tick traffic; send requests are
// limited by the single frame byte the back end emits each cycle. A stalled
// receiver holds the output register; the queue keeps taking requests until it
// fills, and in_if.ready then drops. Reset (rst_n low, synchronous) empties the
// queue, drops any pending reply and restores the timeouts to 12 and 5 ticks.
//
module motor_link_command_framer_unit (
  input logic        clk,
  input logic        rst_n,
  mlcf_in_if.sink    in_if,
  mlcf_out_if.source out_if,
  mlcf_cfg_if.sink   cfg_if
);
  import mlcf_pkg::*;

  desc_t q_din, q_dout;
  logic  q_push, q_pop, q_full, q_empty;

  mlcf_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .cfg_if (cfg_if),
    .q_din  (q_din),
    .q_push (q_push),
    .q_full (q_full)
  );

  mlcf_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  mlcf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_dout  (q_dout),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

`ifndef ASSERT_OFF
  // The front end never writes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("work queue written while full");

  // The back end never reads an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("work queue read while empty");

  // A result without a frame byte always carries a reply outcome.
  a_reply_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.tx_valid) |->
      (out_if.reply_status == ST_OK || out_if.reply_status == ST_FAIL))
    else $error("reply result without status");

  // Nothing is offered in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_if.valid)
    else $error("result offered after reset");
`endif

endmodule

FILE: rtl/core/mlcf_front.sv
// Front end: accepts requests, tracks the reply receiver and queues work for the back end.
`timescale 1ns / 1ps

module mlcf_front (
  input  logic          clk,
  input  logic          rst_n,
  mlcf_in_if.sink       in_if,
  mlcf_cfg_if.sink      cfg_if,
  output mlcf_pkg::desc_t q_din,
  output logic          q_push,
  input  logic          q_full
);
  import mlcf_pkg::*;

  localparam logic [LIM_W-1:0] TICK_MAX = LIM_W'(TICK_MAX_I);

  logic [7:0]            first_to_r, next_to_r;
  logic                  awaiting_r, awaiting_nxt;
  logic [7:0]            exp_addr_r, exp_addr_nxt;
  logic [7:0]            exp_type_r, exp_type_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic [TIMER_BITS-1:0] idle_r, idle_nxt, idle_inc;
  logic [7:0]            chk_r, chk_nxt;
  logic                  ok_r, ok_nxt;
  logic [31:0]           val_r, val_nxt;
  logic                  accept;
  mode_e_t               mode;
  opcode_t               op;
  logic [7:0]            rx;
  logic [15:0]           angle;
  logic [31:0]           payload;
  logic [LIM_W-1:0]      limit_raw, limit, idle_ext;

  assign in_if.ready  = !q_full;
  assign cfg_if.ready = 1'b1;
  assign accept = in_if.valid && in_if.ready;
  assign mode   = mode_e_t'(in_if.mode);
  assign op     = opcode_t'(in_if.opcode);
  assign rx     = in_if.rx_byte;

  // Single angle values are clamped before framing.
  assign angle   = in_if.argument[15:0];
  assign payload = (op == OP_ANGLE) ?
                   {16'd0, ((angle > ANGLE_MAX) ? ANGLE_MAX : angle)} :
                   in_if.argument;

  // Saturating tick counter and the timeout in force, clipped to the counter range.
  assign idle_inc  = (idle_r == TICK_MAX[TIMER_BITS-1:0]) ? idle_r : idle_r + 1'b1;
  assign limit_raw = LIM_W'((cnt_r == 4'd0) ? first_to_r : next_to_r);
  assign limit     = (limit_raw > TICK_MAX) ? TICK_MAX : limit_raw;
  assign idle_ext  = LIM_W'(idle_inc);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_to_r <= FIRST_TO_RST;
      next_to_r  <= NEXT_TO_RST;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_FIRST_TO: first_to_r <= cfg_if.data;
        CFG_NEXT_TO:  next_to_r  <= cfg_if.data;
        default:      ;
      endcase
    end
  end

  // Request classification and reply tracking.
  always_comb begin
    awaiting_nxt = awaiting_r;
    exp_addr_nxt = exp_addr_r;
    exp_type_nxt = exp_type_r;
    cnt_nxt      = cnt_r;
    idle_nxt     = idle_r;
    chk_nxt      = chk_r;
    ok_nxt       = ok_r;
    val_nxt      = val_r;
    q_push       = 1'b0;
    q_din.is_reply = 1'b0;
    q_din.opcode   = op;
    q_din.addr     = in_if.device_addr;
    q_din.value    = payload;
    q_din.status   = ST_NONE;

    if (accept) begin
      unique case (mode)
        MODE_SEND: begin
          q_push = 1'b1;
          if (op == OP_FEEDBACK) begin
            awaiting_nxt = 1'b1;
            exp_addr_nxt = in_if.device_addr;
            exp_type_nxt = in_if.argument[7:0];
            cnt_nxt      = 4'd0;
            idle_nxt     = '0;
          end
        end
        MODE_BYTE: begin
          if (awaiting_r) begin
            idle_nxt = '0;
            cnt_nxt  = cnt_r + 4'd1;
            chk_nxt  = (cnt_r == 4'd0) ? rx : (chk_r ^ rx);
            if (cnt_r == 4'd0) begin
              ok_nxt = (rx == FRAME_HEAD);
            end else if (cnt_r == 4'd1) begin
              ok_nxt = ok_r && (rx == exp_addr_r);
            end else if (cnt_r == 4'd2) begin
              ok_nxt = ok_r && (rx == exp_type_r);
            end else if (cnt_r < REPLY_CHK) begin
              val_nxt = {val_r[23:0], rx};
            end else if (cnt_r == REPLY_CHK) begin
              ok_nxt = ok_r && (rx == chk_r);
            end else begin
              ok_nxt = ok_r && (rx == FRAME_TAIL);
            end
            // Last reply byte: report the outcome and go idle.
            if (cnt_r == REPLY_LAST) begin
              q_push         = 1'b1;
              q_din.is_reply = 1'b1;
              q_din.status   = ok_nxt ? ST_OK : ST_FAIL;
              q_din.value    = ok_nxt ? val_r : 32'd0;
              awaiting_nxt   = 1'b0;
              cnt_nxt        = 4'd0;
            end
          end
        end
        MODE_TICK: begin
          if (awaiting_r) begin
            if (idle_ext >= limit) begin
              q_push         = 1'b1;
              q_din.is_reply = 1'b1;
              q_din.status   = ST_FAIL;
              q_din.value    = 32'd0;
              awaiting_nxt   = 1'b0;
              cnt_nxt        = 4'd0;
              idle_nxt       = '0;
            end else begin
              idle_nxt = idle_inc;
            end
          end
        end
        MODE_NONE: ;
        default: ;
      endcase
    end
  end

  // Receiver state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r <= 1'b0;
      exp_addr_r <= 8'd0;
      exp_type_r <= 8'd0;
      cnt_r      <= 4'd0;
      idle_r     <= '0;
    end else begin
      awaiting_r <= awaiting_nxt;
      exp_addr_r <= exp_addr_nxt;
      exp_type_r <= exp_type_nxt;
      cnt_r      <= cnt_nxt;
      idle_r     <= idle_nxt;
    end
  end

  // Reply check and value accumulators.
  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    ok_r  <= ok_nxt;
    val_r <= val_nxt;
  end

endmodule

FILE: rtl/core/mlcf_queue.sv
// Short work queue between the front and back ends.
`timescale 1ns / 1ps

module mlcf_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mlcf_pkg::desc_t din,
  input  logic            pop,
  output mlcf_pkg::desc_t dout,
  output logic            full,
  output logic            empty
);
  import mlcf_pkg::*;

  desc_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: rtl/core/mlcf_back.sv
// Back end: emits frame bytes and reply results through the output register.
`timescale 1ns / 1ps

module mlcf_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mlcf_pkg::desc_t q_dout,
  input  logic            q_empty,
  output logic            q_pop,
  mlcf_out_if.source      out_if
);
  import mlcf_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  logic        tx_valid_r;
  logic [7:0]  tx_byte_r;
  logic        tx_last_r;
  status_t     status_r;
  logic [31:0] value_r;
  logic [3:0]  idx_r, idx_nxt;
  logic [7:0]  chk_r, chk_nxt;
  logic        advance, load;
  logic [2:0]  plen;
  logic [3:0]  chk_pos, tail_pos, sel;
  logic        last;
  logic [7:0]  frame_byte;

  assign advance = !out_valid_r || out_if.ready;
  assign load    = advance && !q_empty;

  // Byte position within the frame of the queue head.
  assign plen     = payload_len(q_dout.opcode);
  assign chk_pos  = 4'd3 + 4'(plen);
  assign tail_pos = 4'd4 + 4'(plen);
  assign sel      = 4'd2 + 4'(plen) - idx_r;
  assign last     = (idx_r == tail_pos);

  always_comb begin
    if (idx_r == 4'd0) begin
      frame_byte = FRAME_HEAD;
    end else if (idx_r == 4'd1) begin
      frame_byte = q_dout.addr;
    end else if (idx_r == 4'd2) begin
      frame_byte = wire_code(q_dout.opcode);
    end else if (idx_r < chk_pos) begin
      frame_byte = q_dout.value[8*sel[1:0] +: 8];
    end else if (idx_r == chk_pos) begin
      frame_byte = chk_r;
    end else begin
      frame_byte = FRAME_TAIL;
    end
  end

  // Step through the frame; a reply result leaves in one beat.
  always_comb begin
    idx_nxt = idx_r;
    chk_nxt = chk_r;
    q_pop   = 1'b0;
    if (load) begin
      if (q_dout.is_reply) begin
        q_pop = 1'b1;
      end else begin
        chk_nxt = (idx_r == 4'd0) ? frame_byte : (chk_r ^ frame_byte);
        if (last) begin
          q_pop   = 1'b1;
          idx_nxt = 4'd0;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
    end
  end

  assign out_valid_nxt = advance ? !q_empty : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    chk_r <= chk_nxt;
    if (load) begin
      if (q_dout.is_reply) begin
        tx_valid_r <= 1'b0;
        tx_byte_r  <= 8'd0;
        tx_last_r  <= 1'b0;
        status_r   <= q_dout.status;
        value_r    <= q_dout.value;
      end else begin
        tx_valid_r <= 1'b1;
        tx_byte_r  <= frame_byte;
        tx_last_r  <= last;
        status_r   <= ST_NONE;
        value_r    <= 32'd0;
      end
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.tx_valid     = tx_valid_r;
  assign out_if.tx_byte      = tx_byte_r;
  assign out_if.tx_last      = tx_last_r;
  assign out_if.reply_status = status_r;
  assign out_if.reply_value  = value_r;

endmodule

FILE: tb/tb.sv
// Self-checking testbench of the motor link command framer: frames, replies and timeouts.
`timescale 1ns / 1ps

module tb;
  import mlcf_pkg::*;

  // Wire codes that each command carries on the serial link.
  localparam logic [7:0] WIRE_ENABLE   = 8'h06;
  localparam logic [7:0] WIRE_DISABLE  = 8'h05;
  localparam logic [7:0] WIRE_SET_MODE = 8'h00;
  localparam logic [7:0] WIRE_SPEED    = 8'h01;
  localparam logic [7:0] WIRE_POSITION = 8'h02;
  localparam logic [7:0] WIRE_ANGLE    = 8'h03;
  localparam logic [7:0] WIRE_ACCEL    = 8'h07;
  localparam logic [7:0] WIRE_FEEDBACK = 8'h0E;

  localparam int REPLY_BYTES    = 9;
  localparam int SETTLE_LIMIT   = 4000;
  localparam int LATENCY_CYCLES = 16;
  localparam int REPORT_LIMIT   = 10;

  typedef logic [7:0] reply_image_t [REPLY_BYTES];

  typedef enum {
    FLAW_NONE,
    FLAW_HEAD,
    FLAW_ADDR,
    FLAW_TYPE,
    FLAW_CHECK,
    FLAW_TAIL
  } reply_flaw_t;

  // One result as it should leave the block.
  typedef struct {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        tx_last;
    status_t     status;
    logic [31:0] value;
  } link_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mlcf_in_if  in_ch ();
  mlcf_out_if out_ch ();
  mlcf_cfg_if cfg_ch ();

  motor_link_command_framer_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Predicted copy of the block's registers and reply receiver.
  logic [7:0]            reg_first_timeout;
  logic [7:0]            reg_next_timeout;
  logic                  reply_armed;
  logic [7:0]            reply_addr;
  logic [7:0]            reply_kind;
  logic [3:0]            reply_fill;
  logic [7:0]            reply_buf [REPLY_BYTES];
  logic [TIMER_BITS-1:0] reply_idle;

  link_result_t link_results_due [$];
  link_result_t want;

  int mismatch_count;
  int counted_requests;
  int idle_pct;
  int rx_hold_request;
  int rx_hold_left;
  int rx_stall_left;

  always #4 clk = ~clk;

  // Gap length: mostly short, now and then long.
  function automatic int pick_gap();
    if ($urandom_range(9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 24);
  endfunction

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
    end
  endtask

  // Queue the reply outcome and drop back to idle reception.
  function automatic void post_reply(bit ok, logic [31:0] word);
    link_results_due.push_back('{1'b0, 8'h00, 1'b0, ok ? ST_OK : ST_FAIL, ok ? word : 32'h0});
    reply_armed = 1'b0;
    reply_fill  = '0;
    reply_idle  = '0;
  endfunction

  // Work out the results of one accepted request. Returns 1 unless the block ignores it.
  function automatic bit predict_link_outputs(mode_e_t m, opcode_t op, logic [7:0] addr,
                                              logic [31:0] arg, logic [7:0] rxb);
    logic [7:0]  fb [REPLY_BYTES];
    logic [7:0]  code;
    logic [7:0]  chk;
    logic [31:0] payload;
    int          n;
    int          plen;
    int          limit;
    bit          ok;
    case (m)
      MODE_SEND: begin
        payload = arg;
        case (op)
          OP_ENABLE: begin
            code = WIRE_ENABLE;
            plen = 0;
          end
          OP_DISABLE: begin
            code = WIRE_DISABLE;
            plen = 0;
          end
          OP_SET_MODE: begin
            code = WIRE_SET_MODE;
            plen = 2;
          end
          OP_SPEED: begin
            code = WIRE_SPEED;
            plen = 2;
          end
          OP_POSITION: begin
            code = WIRE_POSITION;
            plen = 4;
          end
          OP_ANGLE: begin
            code = WIRE_ANGLE;
            plen = 2;
            payload = (arg[15:0] > ANGLE_MAX) ? {16'h0, ANGLE_MAX} : {16'h0, arg[15:0]};
          end
          OP_ACCEL: begin
            code = WIRE_ACCEL;
            plen = 2;
          end
          default: begin
            code = WIRE_FEEDBACK;
            plen = 1;
          end
        endcase
        fb[0] = FRAME_HEAD;
        fb[1] = addr;
        fb[2] = code;
        n = 3;
        for (int i = plen; i > 0; i--) begin
          fb[n] = payload[8*(i-1) +: 8];
          n++;
        end
        chk = 8'h00;
        for (int i = 0; i < n; i++) begin
          chk ^= fb[i];
        end
        fb[n] = chk;
        fb[n+1] = FRAME_TAIL;
        n += 2;
        for (int i = 0; i < n; i++) begin
          link_results_due.push_back('{1'b1, fb[i], (i == n - 1), ST_NONE, 32'h0});
        end
        // A feedback request restarts reception, abandoning any reply in progress.
        if (op == OP_FEEDBACK) begin
          reply_armed = 1'b1;
          reply_addr  = addr;
          reply_kind  = arg[7:0];
          reply_fill  = '0;
          reply_idle  = '0;
        end
        return 1'b1;
      end
      MODE_BYTE: begin
        if (!reply_armed) begin
          return 1'b0;
        end
        reply_buf[reply_fill] = rxb;
        reply_fill++;
        reply_idle = '0;
        if (reply_fill == REPLY_BYTES) begin
          chk = 8'h00;
          for (int i = 0; i < 7; i++) begin
            chk ^= reply_buf[i];
          end
          ok = reply_buf[0] == FRAME_HEAD && reply_buf[1] == reply_addr &&
               reply_buf[2] == reply_kind && reply_buf[7] == chk &&
               reply_buf[8] == FRAME_TAIL;
          post_reply(ok, {reply_buf[3], reply_buf[4], reply_buf[5], reply_buf[6]});
        end
        return 1'b1;
      end
      MODE_TICK: begin
        if (!reply_armed) begin
          return 1'b0;
        end
        if (reply_idle < TICK_MAX_I) begin
          reply_idle++;
        end
        limit = (reply_fill == 0) ? reg_first_timeout : reg_next_timeout;
        if (limit > TICK_MAX_I) begin
          limit = TICK_MAX_I;
        end
        if (reply_idle >= limit) begin
          post_reply(1'b0, 32'h0);
        end
        return 1'b1;
      end
      default: begin
        return 1'b0;
      end
    endcase
  endfunction

  // Offer one request, after a random gap, and hold it until the block takes it.
  // Called and left at a falling edge; valid stays high for a following request.
  task automatic issue_request(mode_e_t m, opcode_t op, logic [7:0] addr, logic [31:0] arg,
                               logic [7:0] rxb);
    int gap;
    gap = 0;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode        = m;
    in_ch.opcode      = op;
    in_ch.device_addr = addr;
    in_ch.argument    = arg;
    in_ch.rx_byte     = rxb;
    in_ch.valid       = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_link_outputs(m, op, addr, arg, rxb)) begin
      counted_requests++;
    end
    @(negedge clk);
  endtask

  task automatic send_command(opcode_t op, logic [7:0] addr, logic [31:0] arg);
    issue_request(MODE_SEND, op, addr, arg, 8'($urandom));
  endtask

  task automatic feed_byte(logic [7:0] b);
    issue_request(MODE_BYTE, opcode_t'($urandom_range(7)), 8'($urandom), $urandom, b);
  endtask

  task automatic feed_tick();
    issue_request(MODE_TICK, opcode_t'($urandom_range(7)), 8'($urandom), $urandom,
                  8'($urandom));
  endtask

  task automatic feed_noise();
    case ($urandom_range(2))
      0: feed_byte(8'($urandom));
      1: feed_tick();
      default: issue_request(MODE_NONE, opcode_t'($urandom_range(7)), 8'($urandom),
                             $urandom, 8'($urandom));
    endcase
  endtask

  function automatic reply_image_t build_reply(logic [7:0] addr, logic [7:0] kind,
                                               logic [31:0] word, reply_flaw_t flaw);
    reply_image_t img;
    logic [7:0]   spoil;
    img[0] = FRAME_HEAD;
    img[1] = addr;
    img[2] = kind;
    img[3] = word[31:24];
    img[4] = word[23:16];
    img[5] = word[15:8];
    img[6] = word[7:0];
    img[7] = 8'h00;
    for (int i = 0; i < 7; i++) begin
      img[7] ^= img[i];
    end
    img[8] = FRAME_TAIL;
    spoil = 8'($urandom_range(1, 255));
    case (flaw)
      FLAW_HEAD:  img[0] ^= spoil;
      FLAW_ADDR:  img[1] ^= spoil;
      FLAW_TYPE:  img[2] ^= spoil;
      FLAW_CHECK: img[7] ^= spoil;
      FLAW_TAIL:  img[8] ^= spoil;
      default: ;
    endcase
    return img;
  endfunction

  // Deliver the first count bytes of a reply, with up to tick_gap ticks before each.
  task automatic feed_reply(reply_image_t img, int count, int tick_gap);
    for (int i = 0; i < count; i++) begin
      if (tick_gap > 0) begin
        repeat ($urandom_range(tick_gap)) feed_tick();
      end
      feed_byte(img[i]);
    end
  endtask

  // Stop offering and wait until every predicted result has been seen.
  task automatic settle_link();
    int waited;
    waited = 0;
    in_ch.valid = 1'b0;
    while (link_results_due.size() > 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (link_results_due.size() > 0) begin
      mismatch_count += link_results_due.size();
      $display("%0t: %0d expected results never arrived", $realtime, link_results_due.size());
      link_results_due.delete();
    end
    repeat (LATENCY_CYCLES) @(negedge clk);
  endtask

  // Register write; only called once the link has settled.
  task automatic write_timeout(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_FIRST_TO) begin
      reg_first_timeout = val;
    end else begin
      reg_next_timeout = val;
    end
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Receiver: long hold-offs on request, otherwise random stalls.
  always @(negedge clk) begin
    if (rx_hold_request > 0) begin
      rx_hold_left = rx_hold_request;
      rx_hold_request = 0;
    end
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall_left--;
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      rx_stall_left = pick_gap() - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each result that leaves the block with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (link_results_due.size() == 0) begin
        note_mismatch("unexpected result (tx_byte)", 32'h0, out_ch.tx_byte);
      end else begin
        want = link_results_due.pop_front();
        if (out_ch.tx_valid !== want.tx_valid) begin
          note_mismatch("tx_valid", want.tx_valid, out_ch.tx_valid);
        end
        if (out_ch.tx_byte !== want.tx_byte) begin
          note_mismatch("tx_byte", want.tx_byte, out_ch.tx_byte);
        end
        if (out_ch.tx_last !== want.tx_last) begin
          note_mismatch("tx_last", want.tx_last, out_ch.tx_last);
        end
        if (out_ch.reply_status !== want.status) begin
          note_mismatch("reply_status", want.status, out_ch.reply_status);
        end
        if (out_ch.reply_value !== want.value) begin
          note_mismatch("reply_value", want.value, out_ch.reply_value);
        end
      end
    end
  end

  // Bytes and ticks with no reply pending, and the unused mode.
  task automatic test_idle_traffic();
    feed_byte(FRAME_HEAD);
    feed_tick();
    issue_request(MODE_NONE, OP_FEEDBACK, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
    settle_link();
  endtask

  // Every command but feedback, with field extremes, including the angle clamp.
  task automatic test_command_frames();
    send_command(OP_ENABLE, 8'h00, 32'h0000_0000);
    send_command(OP_DISABLE, 8'hFF, 32'hFFFF_FFFF);
    send_command(OP_SET_MODE, 8'h5A, 32'h1234_FFFF);
    send_command(OP_SPEED, 8'hA5, 32'hFFFF_8000);
    send_command(OP_POSITION, 8'h01, 32'h8000_0000);
    send_command(OP_POSITION, 8'hFE, 32'h7FFF_FFFF);
    send_command(OP_ANGLE, 8'h10, 32'd3599);
    send_command(OP_ANGLE, 8'h11, 32'd3600);
    send_command(OP_ANGLE, 8'h12, 32'hFFFF_FFFF);
    send_command(OP_ANGLE, 8'h13, 32'hABCD_0000);
    send_command(OP_ACCEL, 8'h7F, 32'h0000_0001);
    settle_link();
  endtask

  // Reset timeouts: nothing arrives, then a reply stalls after one byte.
  task automatic test_default_timeouts();
    send_command(OP_FEEDBACK, 8'h33, 32'h0000_0044);
    repeat (13) feed_tick();
    send_command(OP_FEEDBACK, 8'h34, 32'h0000_0045);
    feed_byte(FRAME_HEAD);
    repeat (6) feed_tick();
    settle_link();
  endtask

  // Good replies, sends while waiting, abandoned replies and each kind of bad reply.
  task automatic test_reply_handling();
    send_command(OP_FEEDBACK, 8'hFF, 32'hFFFF_FF00);
    issue_request(MODE_NONE, OP_ENABLE, 8'h00, 32'h0, 8'h00);
    send_command(OP_SPEED, 8'h02, 32'h0000_0BB8);
    feed_reply(build_reply(8'hFF, 8'h00, 32'h8000_0000, FLAW_NONE), REPLY_BYTES, 2);
    send_command(OP_FEEDBACK, 8'h00, 32'h0000_00FF);
    feed_reply(build_reply(8'h00, 8'hFF, 32'h0, FLAW_NONE), 4, 0);
    send_command(OP_FEEDBACK, 8'h42, 32'h0000_0003);
    feed_reply(build_reply(8'h42, 8'h03, 32'h7FFF_FFFF, FLAW_NONE), REPLY_BYTES, 0);
    feed_byte(8'h7A);
    for (int f = FLAW_HEAD; f <= FLAW_TAIL; f++) begin
      send_command(OP_FEEDBACK, 8'h21, 32'h0000_0009);
      feed_reply(build_reply(8'h21, 8'h09, $urandom, reply_flaw_t'(f)), REPLY_BYTES, 0);
    end
    send_command(OP_FEEDBACK, 8'h22, 32'h0000_0001);
    feed_reply(build_reply(8'h22, 8'h01, 32'hFFFF_FFFF, FLAW_NONE), REPLY_BYTES, 0);
    settle_link();
  endtask

  // Shortest timeouts fire before and after the first reply byte; with the longest
  // ones a slow reply is still pending after a few ticks.
  task automatic test_timeout_extremes();
    write_timeout(CFG_FIRST_TO, 8'd1);
    write_timeout(CFG_NEXT_TO, 8'd1);
    send_command(OP_FEEDBACK, 8'h05, 32'h0000_0001);
    feed_tick();
    send_command(OP_FEEDBACK, 8'h05, 32'h0000_0001);
    feed_byte(FRAME_HEAD);
    feed_tick();
    settle_link();
    write_timeout(CFG_FIRST_TO, 8'd255);
    write_timeout(CFG_NEXT_TO, 8'd255);
    send_command(OP_FEEDBACK, 8'h06, 32'h0000_0002);
    repeat (6) feed_tick();
    send_command(OP_FEEDBACK, 8'h06, 32'h0000_0002);
    feed_byte(FRAME_HEAD);
    repeat (6) feed_tick();
    settle_link();
  endtask

  // Receiver holds off while commands keep coming, then the sender waits for all results.
  task automatic test_backpressure();
    idle_pct = 0;
    rx_hold_request = 150;
    repeat (12) send_command(opcode_t'($urandom_range(7)), 8'($urandom), $urandom);
    settle_link();
  endtask

  // One feedback exchange with random content, mostly well formed.
  task automatic run_exchange();
    logic [7:0]   addr;
    logic [31:0]  arg;
    reply_flaw_t  flaw;
    reply_image_t img;
    int           count;
    int           tick_gap;
    addr = 8'($urandom);
    arg  = $urandom;
    flaw = ($urandom_range(99) < 70) ? FLAW_NONE : reply_flaw_t'($urandom_range(1, 5));
    img  = build_reply(addr, arg[7:0], $urandom, flaw);
    send_command(OP_FEEDBACK, addr, arg);
    if ($urandom_range(99) < 8) begin
      repeat (reg_first_timeout) feed_tick();
    end else begin
      repeat ($urandom_range(reg_first_timeout - 1)) feed_tick();
    end
    if ($urandom_range(99) < 15) begin
      send_command(opcode_t'($urandom_range(6)), 8'($urandom), $urandom);
    end
    count = ($urandom_range(99) < 10) ? $urandom_range(1, 8) : REPLY_BYTES;
    tick_gap = ($urandom_range(99) < 8) ? reg_next_timeout : reg_next_timeout - 1;
    feed_reply(img, count, tick_gap);
    if (count < REPLY_BYTES) begin
      repeat (reg_next_timeout) feed_tick();
    end
  endtask

  // Random traffic in three phases, each with its own timeouts and idling.
  task automatic test_random_traffic();
    int target;
    int r;
    logic [31:0] arg;
    for (int phase = 0; phase < 3; phase++) begin
      settle_link();
      write_timeout(CFG_FIRST_TO, 8'($urandom_range(2, 10)));
      write_timeout(CFG_NEXT_TO, 8'($urandom_range(2, 4)));
      idle_pct = (phase == 1) ? 0 : ((phase == 0) ? 25 : 50);
      target = counted_requests + 6;
      while (counted_requests < target) begin
        r = $urandom_range(99);
        if (r < 60) begin
          run_exchange();
        end else if (r < 82) begin
          arg = $urandom;
          if ($urandom_range(99) < 30) begin
            arg[15:0] = 16'($urandom_range(3590, 3610));
          end
          send_command(opcode_t'($urandom_range(7)), 8'($urandom), arg);
        end else if (r < 90) begin
          repeat ($urandom_range(1, 4)) feed_tick();
        end else begin
          feed_noise();
        end
      end
    end
    settle_link();
  endtask

  // Run limit.
  initial begin
    #8_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_NONE;
    in_ch.opcode      = OP_ENABLE;
    in_ch.device_addr = 8'h00;
    in_ch.argument    = 32'h0;
    in_ch.rx_byte     = 8'h00;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_FIRST_TO;
    cfg_ch.data       = 8'h00;
    reg_first_timeout = FIRST_TO_RST;
    reg_next_timeout  = NEXT_TO_RST;
    reply_armed       = 1'b0;
    reply_addr        = 8'h00;
    reply_kind        = 8'h00;
    reply_fill        = '0;
    reply_idle        = '0;
    mismatch_count    = 0;
    counted_requests  = 0;
    idle_pct          = 0;
    rx_hold_request   = 0;
    rx_hold_left      = 0;
    rx_stall_left     = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_idle_traffic();
    test_command_frames();
    test_default_timeouts();
    idle_pct = 30;
    test_reply_handling();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
